// File: hdl/rne_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rne_pkg
// Shared constants, symbol table and controller/datapath interface types
// for the Roman numeral encoder.
// ----------------------------------------------------------------------------
package rne_pkg;

  localparam int unsigned ValueBitsDef = 12;
  localparam int unsigned MaxResults   = 15;
  localparam int unsigned CntW         = $clog2(MaxResults);
  localparam int unsigned SymCount     = 13;
  localparam int unsigned SymIdxW      = $clog2(SymCount);
  localparam int unsigned SymValW      = 10;

  localparam logic [7:0] ChM = 8'h4D;
  localparam logic [7:0] ChD = 8'h44;
  localparam logic [7:0] ChC = 8'h43;
  localparam logic [7:0] ChL = 8'h4C;
  localparam logic [7:0] ChX = 8'h58;
  localparam logic [7:0] ChV = 8'h56;
  localparam logic [7:0] ChI = 8'h49;
  localparam logic [7:0] ChNone = 8'h00;

  typedef struct packed {
    logic load;
    logic step;
  } rne_cmd_t;

  typedef struct packed {
    logic last;
  } rne_status_t;

  // symbol table, largest first: M CM D CD C XC L XL X IX V IV I
  function automatic logic [SymValW-1:0] sym_value(input logic [SymIdxW-1:0] idx);
    logic [SymValW-1:0] v;
    unique case (idx)
      4'd0:    v = 10'd1000;
      4'd1:    v = 10'd900;
      4'd2:    v = 10'd500;
      4'd3:    v = 10'd400;
      4'd4:    v = 10'd100;
      4'd5:    v = 10'd90;
      4'd6:    v = 10'd50;
      4'd7:    v = 10'd40;
      4'd8:    v = 10'd10;
      4'd9:    v = 10'd9;
      4'd10:   v = 10'd5;
      4'd11:   v = 10'd4;
      default: v = 10'd1;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] sym_first(input logic [SymIdxW-1:0] idx);
    logic [7:0] c;
    unique case (idx)
      4'd0:    c = ChM;
      4'd1:    c = ChC;
      4'd2:    c = ChD;
      4'd3:    c = ChC;
      4'd4:    c = ChC;
      4'd5:    c = ChX;
      4'd6:    c = ChL;
      4'd7:    c = ChX;
      4'd8:    c = ChX;
      4'd9:    c = ChI;
      4'd10:   c = ChV;
      4'd11:   c = ChI;
      default: c = ChI;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] sym_second(input logic [SymIdxW-1:0] idx);
    logic [7:0] c;
    unique case (idx)
      4'd1:    c = ChM;
      4'd3:    c = ChD;
      4'd5:    c = ChC;
      4'd7:    c = ChL;
      4'd9:    c = ChX;
      4'd11:   c = ChV;
      default: c = ChNone;
    endcase
    return c;
  endfunction

  function automatic logic sym_pair(input logic [SymIdxW-1:0] idx);
    return idx[0] && (idx < SymIdxW'(SymCount - 1));
  endfunction

endpackage

`default_nettype wire

// File: hdl/rne_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rne_ctrl
// Controller: accepts a request, then steps the datapath one character per
// cycle until the final character of the run.
// ----------------------------------------------------------------------------
module rne_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire rne_pkg::rne_status_t status_i,
  output rne_pkg::rne_cmd_t         cmd_o,
  output logic                      busy_o
);
  import rne_pkg::*;

  localparam logic StIdle = 1'b0;
  localparam logic StRun  = 1'b1;

  logic state_q, state_d;

  always_comb begin
    cmd_o.load = 1'b0;
    cmd_o.step = 1'b0;
    state_d    = state_q;
    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = StRun;
        end
      end
      default: begin
        cmd_o.step = 1'b1;
        if (status_i.last) begin
          state_d = StIdle;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q == StRun);

endmodule

`default_nettype wire

// File: hdl/rne_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rne_datapath
// Remainder register, greedy symbol select, character counter and the
// registered result outputs.
// ----------------------------------------------------------------------------
module rne_datapath #(
  parameter int unsigned VALUE_BITS = rne_pkg::ValueBitsDef
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire rne_pkg::rne_cmd_t     cmd_i,
  input  wire logic [VALUE_BITS-1:0] value_i,
  output rne_pkg::rne_status_t       status_o,
  output logic                       valid_o,
  output logic [7:0]                 numeral_char_o,
  output logic                       last_o,
  output logic                       error_o
);
  import rne_pkg::*;

  localparam int unsigned CmpW = (VALUE_BITS > SymValW) ? VALUE_BITS : SymValW;

  logic [VALUE_BITS-1:0] n_q;
  logic                  phase_q;
  logic [CntW-1:0]       cnt_q;
  logic                  zero_q;
  logic                  valid_q;
  logic [7:0]            char_q;
  logic                  last_q;
  logic                  error_q;

  logic [CmpW-1:0]       n_ext;
  logic [CmpW-1:0]       sym_ext;
  logic [SymIdxW-1:0]    idx;
  logic [CmpW-1:0]       rem;
  logic                  sym_done;
  logic [7:0]            ch;
  logic                  last_char;

  assign n_ext = CmpW'(n_q);

  always_comb begin
    idx = SymIdxW'(SymCount - 1);
    for (int i = SymCount - 1; i >= 0; i--) begin
      if (n_ext >= CmpW'(sym_value(SymIdxW'(i)))) begin
        idx = SymIdxW'(i);
      end
    end
  end

  assign sym_ext   = CmpW'(sym_value(idx));
  assign rem       = n_ext - sym_ext;
  assign sym_done  = !sym_pair(idx) || phase_q;
  assign ch        = phase_q ? sym_second(idx) : sym_first(idx);
  assign last_char = zero_q || (cnt_q == CntW'(MaxResults - 1)) ||
                     (sym_done && (rem == '0));

  assign status_o.last = last_char;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      n_q     <= value_i;
      phase_q <= 1'b0;
      cnt_q   <= '0;
      zero_q  <= (value_i == '0);
    end else if (cmd_i.step) begin
      if (sym_done) begin
        n_q     <= rem[VALUE_BITS-1:0];
        phase_q <= 1'b0;
      end else begin
        phase_q <= 1'b1;
      end
      cnt_q <= cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      char_q  <= zero_q ? ChNone : ch;
      last_q  <= last_char;
      error_q <= zero_q;
    end
  end

  assign valid_o        = valid_q;
  assign numeral_char_o = char_q;
  assign last_o         = last_q;
  assign error_o        = error_q;

endmodule

`default_nettype wire

// File: hdl/roman_numeral_encoder_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// roman_numeral_encoder_core
// Converts an unsigned integer to its Roman numeral, one ASCII character
// per valid_o strobe, most significant first, last_o on the final one.
// ----------------------------------------------------------------------------
// A request is taken only while idle and loaded into the remainder register;
// its N characters (1..15) are then registered on the result outputs, one
//   per cycle from a single compare-and-subtract on the remainder register.
// A zero value gives one error result. The receiver cannot stall.
// Reset: asynchronous, clears the controller and the result strobe.
module roman_numeral_encoder_core #(
  parameter int unsigned VALUE_BITS = rne_pkg::ValueBitsDef
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  output logic                       busy_o,
  input  wire logic [VALUE_BITS-1:0] value_i,
  output logic                       valid_o,
  output logic [7:0]                 numeral_char_o,
  output logic                       last_o,
  output logic                       error_o
);
  import rne_pkg::*;

  rne_cmd_t    cmd;
  rne_status_t status;

  rne_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  rne_datapath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .value_i        (value_i),
    .status_o       (status),
    .valid_o        (valid_o),
    .numeral_char_o (numeral_char_o),
    .last_o         (last_o),
    .error_o        (error_o)
  );

endmodule

`default_nettype wire

// File: hdl/rne_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rne_checker
// Port-level checks on request acceptance and the result stream.
// ----------------------------------------------------------------------------
module rne_checker #(
  parameter int unsigned VALUE_BITS = rne_pkg::ValueBitsDef
) (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  start_i,
  input wire logic                  busy_o,
  input wire logic [VALUE_BITS-1:0] value_i,
  input wire logic                  valid_o,
  input wire logic [7:0]            numeral_char_o,
  input wire logic                  last_o,
  input wire logic                  error_o
);
  import rne_pkg::*;

  logic req_zero;
  assign req_zero = start_i && !busy_o && (value_i == '0);

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("request accepted but busy_o not raised");

  a_busy_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |=> valid_o)
    else $error("busy cycle produced no result");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && last_o) |-> !busy_o)
    else $error("still busy after final result");

  a_zero_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_zero |=> ##1 (valid_o && error_o && last_o && (numeral_char_o == ChNone)))
    else $error("zero request did not give a single error result");

  a_char_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !error_o) |-> ((numeral_char_o == ChM) || (numeral_char_o == ChD) ||
      (numeral_char_o == ChC) || (numeral_char_o == ChL) || (numeral_char_o == ChX) ||
      (numeral_char_o == ChV) || (numeral_char_o == ChI)))
    else $error("result is not a numeral character");

endmodule

bind roman_numeral_encoder_core rne_checker #(
  .VALUE_BITS (VALUE_BITS)
) u_rne_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .value_i        (value_i),
  .valid_o        (valid_o),
  .numeral_char_o (numeral_char_o),
  .last_o         (last_o),
  .error_o        (error_o)
);

`default_nettype wire

// File: tb/tb_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for roman_numeral_encoder_core: drives integer
// requests under varying sender idle rates and checks every output
// character strobe against typed numerals or an in-bench numeral predictor.
// ----------------------------------------------------------------------------
module tb_top;

  import rne_pkg::*;

  localparam int unsigned VALUE_BITS = ValueBitsDef;
  localparam int unsigned DIR_ROWS   = 21;
  localparam int unsigned RAND_ITEMS = 110;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       err;
  } numeral_res_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  start_i;
  logic                  busy_o;
  logic [VALUE_BITS-1:0] value_i;
  logic                  valid_o;
  logic [7:0]            numeral_char_o;
  logic                  last_o;
  logic                  error_o;

  // typed expectation travels with the request
  logic  req_typed;
  string req_numeral;

  numeral_res_t numeral_q[$];
  int unsigned  fail_cnt;

  roman_numeral_encoder_core #(
    .VALUE_BITS(VALUE_BITS)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .value_i       (value_i),
    .valid_o       (valid_o),
    .numeral_char_o(numeral_char_o),
    .last_o        (last_o),
    .error_o       (error_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #200000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic void predict_numeral(input logic [VALUE_BITS-1:0] v);
    logic [7:0]  chars[$];
    logic [7:0]  one, five, ten;
    int unsigned n, d;
    numeral_res_t r;
    n = v;
    if (n == 0) begin
      r = '{ch: ChNone, last: 1'b1, err: 1'b1};
      numeral_q.push_back(r);
      return;
    end
    for (int unsigned t = 0; t < n / 1000; t++) chars.push_back(ChM);
    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin
          one = ChC; five = ChD; ten = ChM; d = (n / 100) % 10;
        end
        1: begin
          one = ChX; five = ChL; ten = ChC; d = (n / 10) % 10;
        end
        default: begin
          one = ChI; five = ChV; ten = ChX; d = n % 10;
        end
      endcase
      if (d >= 9) begin
        d -= 9; chars.push_back(one); chars.push_back(ten);
      end
      if (d >= 5) begin
        d -= 5; chars.push_back(five);
      end
      if (d >= 4) begin
        d -= 4; chars.push_back(one); chars.push_back(five);
      end
      while (d > 0) begin
        d--; chars.push_back(one);
      end
    end
    while (chars.size() > MaxResults) void'(chars.pop_back());
    foreach (chars[k]) begin
      r = '{ch: chars[k], last: (k == chars.size() - 1), err: 1'b0};
      numeral_q.push_back(r);
    end
  endfunction

  // empty string stands for the zero-value error result
  function automatic void push_typed(input string s);
    numeral_res_t r;
    if (s.len() == 0) begin
      r = '{ch: ChNone, last: 1'b1, err: 1'b1};
      numeral_q.push_back(r);
    end else begin
      for (int k = 0; k < s.len(); k++) begin
        r = '{ch: s[k], last: (k == s.len() - 1), err: 1'b0};
        numeral_q.push_back(r);
      end
    end
  endfunction

  always @(posedge clk_i) begin
    numeral_res_t want;
    if (rst_ni && start_i && !busy_o) begin
      if (req_typed) push_typed(req_numeral);
      else predict_numeral(value_i);
    end
    if (rst_ni && valid_o) begin
      if (numeral_q.size() == 0) begin
        $display("%0t: unexpected result char=%h last=%b error=%b", $time,
                 numeral_char_o, last_o, error_o);
        fail_cnt++;
      end else begin
        want = numeral_q.pop_front();
        if (numeral_char_o !== want.ch) begin
          $display("%0t: numeral_char expected %h actual %h", $time, want.ch,
                   numeral_char_o);
          fail_cnt++;
        end
        if (last_o !== want.last) begin
          $display("%0t: last expected %b actual %b", $time, want.last, last_o);
          fail_cnt++;
        end
        if (error_o !== want.err) begin
          $display("%0t: error expected %b actual %b", $time, want.err, error_o);
          fail_cnt++;
        end
      end
    end
  end

  // called at a rising edge; returns at the edge that accepts the request
  task automatic send_request(input logic [VALUE_BITS-1:0] v, input logic typed,
                              input string s);
    logic took;
    start_i     <= 1'b1;
    value_i     <= v;
    req_typed   <= typed;
    req_numeral <= s;
    took = 1'b0;
    while (!took) begin
      @(negedge clk_i);
      took = !busy_o;
      @(posedge clk_i);
    end
  endtask

  task automatic sender_gap(input int unsigned idle_pct);
    if ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
    end
  endtask

  logic [VALUE_BITS-1:0] dir_value   [DIR_ROWS];
  logic                  dir_typed   [DIR_ROWS];
  string                 dir_numeral [DIR_ROWS];
  int unsigned           idle_pct    [4];

  initial begin
    logic [VALUE_BITS-1:0] v;
    int unsigned           wait_cnt;
    dir_value   = '{0, 1, 4, 9, 5, 40, 90, 400, 900, 1000, 3888, 4095, 4000, 3999,
                    1994, 2730, 1365, 2048, 14, 444, 0};
    dir_typed   = '{1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1,
                    0, 0, 0, 0, 0, 0, 1};
    dir_numeral = '{"", "I", "IV", "IX", "V", "XL", "XC", "CD", "CM", "M",
                    "MMMDCCCLXXXVIII", "MMMMXCV", "MMMM", "MMMCMXCIX",
                    "", "", "", "", "", "", ""};
    idle_pct    = '{0, 61, 0, 38};
    fail_cnt    = 0;
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    value_i     = '0;
    req_typed   = 1'b0;
    req_numeral = "";
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIR_ROWS; i++) begin
      send_request(dir_value[i], dir_typed[i], dir_numeral[i]);
    end

    for (int ph = 0; ph < 4; ph++) begin
      for (int i = 0; i < RAND_ITEMS / 4; i++) begin
        sender_gap(idle_pct[ph]);
        case ($urandom_range(9))
          0:       v = '0;
          1, 2:    v = VALUE_BITS'($urandom_range(1, 40));
          3:       v = VALUE_BITS'($urandom_range(3800, 3999));
          default: v = VALUE_BITS'($urandom_range(0, (1 << VALUE_BITS) - 1));
        endcase
        send_request(v, 1'b0, "");
      end
    end
    start_i <= 1'b0;

    wait_cnt = 0;
    while (numeral_q.size() != 0 && wait_cnt < 2000) begin
      @(posedge clk_i);
      wait_cnt++;
    end
    repeat (20) @(posedge clk_i);
    if (numeral_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, numeral_q.size());
      fail_cnt++;
    end

    if (fail_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
